// ----- sv/slmt_pkg.sv -----
// Shared types, constants and helpers for the scrolling LED matrix text driver.
// Used by every module of the block; depends on nothing else.
package slmt_pkg;

  // Defaults for the top-level parameters.
  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int FONT_GLYPHS_DEF  = 96;

  // Field widths of the stream items.
  localparam int OP_W     = 2;
  localparam int CHAR_W   = 8;
  localparam int FADDR_W  = 10;
  localparam int ROW_W    = 8;
  localparam int BCOUNT_W = 7;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Glyph geometry and character mapping.
  localparam int GLYPH_ROWS = 8;
  localparam logic [CHAR_W-1:0] FIRST_GLYPH_CODE = 8'h20;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DELAY_W    = 16;
  localparam logic CFG_REG_SCROLL_DELAY = 1'b0;
  localparam logic [DELAY_W-1:0] SCROLL_DELAY_RESET = 16'd64;

  // Item operations.
  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_TICK  = 2'd1,
    OP_FONT  = 2'd2,
    OP_PURGE = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample;  // block idle: read memories at the current state
    logic load;    // an input item is taken this cycle
    logic exec;    // apply the held item and load the result register
  } cmd_t;

  // Mirror a byte so that bit 0 drives the leftmost column.
  function automatic logic [ROW_W-1:0] flip_byte(input logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    for (int i = 0; i < ROW_W; i++) begin
      r[ROW_W-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

// ----- sv/scrolling_led_matrix_text.sv -----
// Top level of the scrolling LED matrix text driver.
// Instantiates slmt_cfg, slmt_ctrl and slmt_dpath; depends on slmt_pkg.
//
// Usage: every input item carries an operation in s_axis_tuser: put a character
// into the ring, tick one row scan, write one font row, or purge the queue and
// scroll state. Each item gives exactly one result item on the master side,
// with the column drive and active-low row select for a tick, the put's accept
// flag, the busy flag and the number of queued characters.
// The font memory must be loaded by font writes before glyphs are shown.
// Timing: an item is taken while the block is idle and held; it is applied in
// the execute state, which loads the result register, and the next item is not
// taken before the block is back in idle. The execute state exists because
// the two glyph rows come from the synchronous font memory.
// Stalls: a result waits in the output register while m_axis_tready is low;
// the block holds the next item until that register frees up.
// Reset: queue, pointers, scroll state and busy flag clear at once; the scroll
// delay returns to 64. The ring and font contents are not cleared.
// The scroll delay register sits at APB byte address 0 and should be written
// only while the block is idle.
module scrolling_led_matrix_text #(
  parameter int BUFFER_DEPTH = slmt_pkg::BUFFER_DEPTH_DEF,
  parameter int FONT_GLYPHS  = slmt_pkg::FONT_GLYPHS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: char_code[7:0], font_address[17:8], font_row_data[25:18], zero pad
  input  logic [slmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [slmt_pkg::OP_W-1:0]         s_axis_tuser,
  // Result items.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: column_bits[7:0], row_select_n[15:8], accepted[16], busy_res[17],
  //        buffered_count[24:18], zero pad
  output logic [slmt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slmt_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [slmt_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [slmt_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  slmt_pkg::cmd_t               cmd;
  logic [slmt_pkg::DELAY_W-1:0] scroll_delay;

  slmt_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .scroll_delay_o (scroll_delay)
  );

  slmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  slmt_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .FONT_GLYPHS  (FONT_GLYPHS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .op_i            (slmt_pkg::op_e'(s_axis_tuser)),
    .char_code_i     (s_axis_tdata[7:0]),
    .font_address_i  (s_axis_tdata[17:8]),
    .font_row_data_i (s_axis_tdata[25:18]),
    .scroll_delay_i  (scroll_delay),
    .out_data_o      (m_axis_tdata)
  );

endmodule

// ----- sv/slmt_cfg.sv -----
// Configuration register file of the scrolling LED matrix text driver.
// Holds the scroll delay behind an APB-style port; depends on slmt_pkg.
module slmt_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slmt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [slmt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [slmt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [slmt_pkg::DELAY_W-1:0]     scroll_delay_o
);

  logic [slmt_pkg::DELAY_W-1:0] scroll_delay_q;
  logic                         sel_delay;

  // Only word zero is decoded; other words read as zero and ignore writes.
  assign sel_delay = (paddr[2] == slmt_pkg::CFG_REG_SCROLL_DELAY);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_delay_q <= slmt_pkg::SCROLL_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && sel_delay) begin
      scroll_delay_q <= pwdata[slmt_pkg::DELAY_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (sel_delay) begin
      prdata = slmt_pkg::CFG_DATA_W'(scroll_delay_q);
    end
  end

  assign scroll_delay_o = scroll_delay_q;

endmodule

// ----- sv/slmt_ctrl.sv -----
// Controller of the scrolling LED matrix text driver: item sequencing and
// the result register's valid flag. Depends on slmt_pkg.
module slmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slmt_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state: take an item when idle, apply it once the result slot is free.
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.sample = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.exec   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.sample = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // An accepted item is applied in a later cycle, never in the same one.
  a_load_not_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.exec))
    else $error("load and exec in the same cycle");

  // Applying an item always leaves a result on offer.
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("applied item left no result");

  // A result that is not taken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while stalled");

endmodule

// ----- sv/slmt_dpath.sv -----
// Datapath of the scrolling LED matrix text driver: character ring, font
// memory, scroll state and the result register. Depends on slmt_pkg.
module slmt_dpath #(
  parameter int BUFFER_DEPTH = slmt_pkg::BUFFER_DEPTH_DEF,
  parameter int FONT_GLYPHS  = slmt_pkg::FONT_GLYPHS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  slmt_pkg::cmd_t                    cmd_i,
  input  slmt_pkg::op_e                     op_i,
  input  logic [slmt_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [slmt_pkg::FADDR_W-1:0]      font_address_i,
  input  logic [slmt_pkg::ROW_W-1:0]        font_row_data_i,
  input  logic [slmt_pkg::DELAY_W-1:0]      scroll_delay_i,
  output logic [slmt_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int FONT_ROWS = FONT_GLYPHS * slmt_pkg::GLYPH_ROWS;
  localparam int PTR_W     = $clog2(BUFFER_DEPTH);
  localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int FIDX_W    = (FONT_ROWS > 1) ? $clog2(FONT_ROWS) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

  localparam int CW = slmt_pkg::CHAR_W;
  localparam int RW = slmt_pkg::ROW_W;

  // Held input item.
  slmt_pkg::op_e            op_q;
  logic [CW-1:0]            code_q;
  logic [slmt_pkg::FADDR_W-1:0] faddr_q;
  logic [RW-1:0]            fdata_q;

  // Memories and their registered read data.
  logic [CW-1:0] ring_mem [BUFFER_DEPTH];
  logic [RW-1:0] font_mem [FONT_ROWS];
  logic [CW-1:0] ring_rd_q;
  logic [RW-1:0] cur_row_q, fol_row_q;
  logic          cur_ok_q, fol_ok_q;

  // Scroll and queue state.
  logic [PTR_W-1:0]            rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]               cur_q, cur_d, fol_q, fol_d;
  logic [2:0]                  row_q, row_d, off_q, off_d;
  logic [slmt_pkg::DELAY_W-1:0] dly_q, dly_d;
  logic                        busy_q, busy_d;

  logic [slmt_pkg::OUT_DATA_W-1:0] out_q;

  // Font lookup addresses for the rows of the current and following glyphs.
  logic [CW-1:0]     cur_g, fol_g;
  logic              cur_ok, fol_ok;
  logic [FIDX_W-1:0] cur_idx, fol_idx;

  assign cur_g  = cur_q - slmt_pkg::FIRST_GLYPH_CODE;
  assign fol_g  = fol_q - slmt_pkg::FIRST_GLYPH_CODE;
  assign cur_ok = (cur_q >= slmt_pkg::FIRST_GLYPH_CODE) &&
                  ({1'b0, cur_g} < (CW + 1)'(FONT_GLYPHS));
  assign fol_ok = (fol_q >= slmt_pkg::FIRST_GLYPH_CODE) &&
                  ({1'b0, fol_g} < (CW + 1)'(FONT_GLYPHS));
  assign cur_idx = cur_ok ? FIDX_W'({cur_g, row_q}) : '0;
  assign fol_idx = fol_ok ? FIDX_W'({fol_g, row_q}) : '0;

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      code_q  <= char_code_i;
      faddr_q <= font_address_i;
      fdata_q <= font_row_data_i;
    end
  end

  // Memory reads while idle, memory writes when an item is applied.
  logic ring_we, font_we;
  assign ring_we = cmd_i.exec && (op_q == slmt_pkg::OP_PUT) && (cnt_q < CNT_FULL);
  assign font_we = cmd_i.exec && (op_q == slmt_pkg::OP_FONT) &&
                   (32'(faddr_q) < FONT_ROWS);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= code_q;
    end
    if (cmd_i.sample) begin
      ring_rd_q <= ring_mem[rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[FIDX_W'(faddr_q)] <= fdata_q;
    end
    if (cmd_i.sample) begin
      cur_row_q <= font_mem[cur_idx];
      fol_row_q <= font_mem[fol_idx];
      cur_ok_q  <= cur_ok;
      fol_ok_q  <= fol_ok;
    end
  end

  // Row blend: shift the glyph pair left by the scroll offset.
  logic [RW-1:0]   a_row, b_row, blend;
  logic [2*RW-1:0] pair;
  assign a_row = cur_ok_q ? cur_row_q : '0;
  assign b_row = fol_ok_q ? fol_row_q : '0;
  assign pair  = {a_row, b_row} << off_q;
  assign blend = pair[2*RW-1:RW];

  // Next state and result fields of the held item.
  logic [RW-1:0] cols, rows;
  logic          acc;
  logic [2:0]    off_inc;

  always_comb begin
    rp_d   = rp_q;
    wp_d   = wp_q;
    cnt_d  = cnt_q;
    cur_d  = cur_q;
    fol_d  = fol_q;
    row_d  = row_q;
    off_d  = off_q;
    dly_d  = dly_q;
    busy_d = busy_q;
    cols   = '0;
    rows   = '1;
    acc    = 1'b0;
    off_inc = off_q + 3'd1;
    unique case (op_q)
      slmt_pkg::OP_PUT: begin
        if (cnt_q < CNT_FULL) begin
          busy_d = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          wp_d   = (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
          acc    = 1'b1;
        end
      end
      slmt_pkg::OP_TICK: begin
        cols  = slmt_pkg::flip_byte(blend);
        rows  = ~(RW'(1) << row_q);
        row_d = row_q + 3'd1;
        if ((dly_q >= scroll_delay_i) || (cur_q == '0)) begin
          dly_d = '0;
          off_d = off_inc;
          if ((off_inc == 3'd0) || (cur_q == '0)) begin
            // Glyph boundary: shift in the next queued character.
            off_d = '0;
            cur_d = fol_q;
            if (cnt_q == '0) begin
              fol_d = '0;
            end else begin
              fol_d  = ring_rd_q;
              cnt_d  = cnt_q - CNT_W'(1);
              rp_d   = (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
              busy_d = !((ring_rd_q == '0) && (fol_q == '0));
            end
          end
        end else begin
          dly_d = dly_q + slmt_pkg::DELAY_W'(1);
        end
      end
      slmt_pkg::OP_FONT: begin
      end
      slmt_pkg::OP_PURGE: begin
        rp_d   = '0;
        wp_d   = '0;
        cnt_d  = '0;
        cur_d  = '0;
        fol_d  = '0;
        row_d  = '0;
        off_d  = '0;
        dly_d  = '0;
        busy_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Queue and scroll state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      cnt_q  <= '0;
      cur_q  <= '0;
      fol_q  <= '0;
      row_q  <= '0;
      off_q  <= '0;
      dly_q  <= '0;
      busy_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      cnt_q  <= cnt_d;
      cur_q  <= cur_d;
      fol_q  <= fol_d;
      row_q  <= row_d;
      off_q  <= off_d;
      dly_q  <= dly_d;
      busy_q <= busy_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= slmt_pkg::OUT_DATA_W'({slmt_pkg::BCOUNT_W'(cnt_d), busy_d, acc, rows, cols});
    end
  end

  assign out_data_o = out_q;

  // The fill count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("ring fill count beyond depth");

  // The write pointer leads the read pointer by the fill count, modulo the depth.
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(rp_q) + int'(cnt_q) == int'(wp_q)) ||
    (int'(rp_q) + int'(cnt_q) == int'(wp_q) + BUFFER_DEPTH))
    else $error("ring pointers disagree with fill count");

  // Every tick moves the scan to the next row.
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (op_q == slmt_pkg::OP_TICK)) |=> (row_q == $past(row_q) + 3'd1))
    else $error("scan row did not advance on tick");

endmodule

// ----- tb/sv/tb_scrolling_led_matrix_text.sv -----
// Self-checking testbench for the scrolling LED matrix text driver.
// Drives items and APB writes, predicts every result item and compares it.
// Depends on slmt_pkg and scrolling_led_matrix_text only.
module tb_scrolling_led_matrix_text;
  timeunit 1ns;
  timeprecision 1ps;
  import slmt_pkg::*;

  localparam int RING_DEPTH   = BUFFER_DEPTH_DEF;
  localparam int FONT_GLYPHS  = FONT_GLYPHS_DEF;
  localparam int FONT_ROWS    = FONT_GLYPHS * GLYPH_ROWS;
  localparam int RESET_CYCLES = 6;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 4;
  localparam int RANDOM_ITEMS = 90;
  localparam int CALM_TAIL    = 30;
  localparam logic [CFG_ADDR_W-1:0] SCROLL_DELAY_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR    = 3'd4;

  // One predicted matrix drive word, as carried by a result item.
  typedef struct packed {
    logic [ROW_W-1:0]    cols;
    logic [ROW_W-1:0]    rows;
    logic                acc;
    logic                busy;
    logic [BCOUNT_W-1:0] count;
  } drive_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predicted display state.
  logic [CHAR_W-1:0]   ring_mem [RING_DEPTH];
  logic [ROW_W-1:0]    font_rows [FONT_ROWS];
  logic [5:0]          rd_ptr = '0;
  logic [5:0]          wr_ptr = '0;
  logic [BCOUNT_W-1:0] queued = '0;
  logic [CHAR_W-1:0]   cur_code = '0;
  logic [CHAR_W-1:0]   next_code = '0;
  logic [2:0]          row_idx = '0;
  logic [2:0]          col_shift = '0;
  logic [DELAY_W-1:0]  tick_cnt = '0;
  logic                busy = 1'b0;
  logic [DELAY_W-1:0]  delay_reg = SCROLL_DELAY_RESET;

  drive_t predicted_q[$];
  bit     idle_on = 1'b1;
  bit     hold_req = 1'b0;
  int     mismatches = 0;
  int     results_checked = 0;
  int     refused_puts = 0;
  int     delay_settings = 0;
  int     op_seen [4] = '{0, 0, 0, 0};
  int     quiet_cycles = 0;

  scrolling_led_matrix_text u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Glyph row of a character; anything outside the font is dark.
  function automatic logic [ROW_W-1:0] glyph_bits(logic [CHAR_W-1:0] code, logic [2:0] row);
    int g;
    g = int'(code) - int'(FIRST_GLYPH_CODE);
    if (g < 0 || g >= FONT_GLYPHS) return '0;
    return font_rows[g * GLYPH_ROWS + int'(row)];
  endfunction

  // Take the next queued character, or a gap when the ring is empty.
  function automatic logic [CHAR_W-1:0] pop_char();
    logic [CHAR_W-1:0] c;
    if (queued == 0) return '0;
    c = ring_mem[rd_ptr];
    queued = queued - 1'b1;
    rd_ptr = rd_ptr + 1'b1;
    busy = !(c == 0 && cur_code == 0 && next_code == 0);
    return c;
  endfunction

  // Apply one item to the predicted state and return its drive word.
  function automatic drive_t advance_display(op_e op, logic [CHAR_W-1:0] code,
                                             logic [FADDR_W-1:0] addr,
                                             logic [ROW_W-1:0] data);
    drive_t d;
    logic [ROW_W-1:0] a, b, blend;
    int sh;
    d = '0;
    d.rows = '1;
    op_seen[int'(op)]++;
    case (op)
      OP_PUT: begin
        if (int'(queued) < RING_DEPTH) begin
          busy = 1'b1;
          ring_mem[wr_ptr] = code;
          queued = queued + 1'b1;
          wr_ptr = wr_ptr + 1'b1;
          d.acc = 1'b1;
        end else begin
          refused_puts++;
        end
      end
      OP_TICK: begin
        a = (cur_code == 0) ? '0 : glyph_bits(cur_code, row_idx);
        b = (next_code == 0) ? '0 : glyph_bits(next_code, row_idx);
        if (col_shift == 0) begin
          blend = a;
        end else begin
          sh = (int'(a) << col_shift) | (int'(b) >> (8 - int'(col_shift)));
          blend = sh[ROW_W-1:0];
        end
        d.cols = {<<{blend}};
        d.rows = ~(8'h01 << row_idx);
        row_idx = row_idx + 1'b1;
        // Blank current characters scroll past at once.
        if (int'(tick_cnt) + 1 > int'(delay_reg) || cur_code == 0) begin
          tick_cnt = '0;
          col_shift = col_shift + 1'b1;
          if (col_shift == 0 || cur_code == 0) begin
            col_shift = '0;
            cur_code = next_code;
            next_code = pop_char();
          end
        end else begin
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      OP_FONT: begin
        if (int'(addr) < FONT_ROWS) font_rows[addr] = data;
      end
      default: begin
        rd_ptr = '0;
        wr_ptr = '0;
        queued = '0;
        cur_code = '0;
        next_code = '0;
        row_idx = '0;
        col_shift = '0;
        tick_cnt = '0;
        busy = 1'b0;
      end
    endcase
    d.busy = busy;
    d.count = queued;
    return d;
  endfunction

  // Compare each result item with the oldest prediction, then predict new items.
  always @(posedge clk_i) begin : drive_checker
    drive_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cols  = m_axis_tdata[7:0];
        got.rows  = m_axis_tdata[15:8];
        got.acc   = m_axis_tdata[16];
        got.busy  = m_axis_tdata[17];
        got.count = m_axis_tdata[24:18];
        results_checked++;
        if (predicted_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result item, nothing predicted:", $time,
                   " cols=%h rows=%h acc=%b busy=%b count=%0d",
                   got.cols, got.rows, got.acc, got.busy, got.count);
        end else begin
          want = predicted_q.pop_front();
          if (got.cols !== want.cols || got.rows !== want.rows || got.acc !== want.acc ||
              got.busy !== want.busy || got.count !== want.count) begin
            mismatches++;
            $display("%0t: mismatch: expected cols=%h rows=%h acc=%b busy=%b count=%0d,",
                     $time, want.cols, want.rows, want.acc, want.busy, want.count,
                     " got cols=%h rows=%h acc=%b busy=%b count=%0d",
                     got.cols, got.rows, got.acc, got.busy, got.count);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        predicted_q.push_back(advance_display(op_e'(s_axis_tuser), s_axis_tdata[7:0],
                                              s_axis_tdata[17:8], s_axis_tdata[25:18]));
    end
  end

  // End the run when neither side has moved an item for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Result-side ready: random stalls, or one long hold when requested.
  initial begin : result_ready_gen
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one item and wait for its handshake; valid stays high unless a gap follows.
  task automatic send_item(op_e op, logic [CHAR_W-1:0] code, logic [FADDR_W-1:0] addr,
                           logic [ROW_W-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'b0, data, addr, code};
    do @(posedge clk_i); while (!s_axis_tready);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic put_char(logic [CHAR_W-1:0] code);
    send_item(OP_PUT, code, FADDR_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic tick();
    send_item(OP_TICK, CHAR_W'($urandom), FADDR_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic purge();
    send_item(OP_PURGE, CHAR_W'($urandom), FADDR_W'($urandom), ROW_W'($urandom));
  endtask

  // Mostly printable glyphs, with gaps and dark codes mixed in.
  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CHAR_W'($urandom_range(32, 127));
    if (r < 75) return '0;
    if (r < 85) return CHAR_W'($urandom_range(1, 31));
    return CHAR_W'($urandom_range(128, 255));
  endfunction

  // Stop offering and wait until every predicted result has come back.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (predicted_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == SCROLL_DELAY_ADDR) delay_reg = wdata[DELAY_W-1:0];
  endtask

  task automatic write_scroll_delay(logic [DELAY_W-1:0] dly);
    apb_write(SCROLL_DELAY_ADDR, {16'($urandom), dly});
    delay_settings++;
  endtask

  task automatic send_random_item(int put_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < put_pct)
      put_char(pick_char());
    else if (r < put_pct + 6)
      send_item(OP_FONT, CHAR_W'($urandom), FADDR_W'($urandom), ROW_W'($urandom));
    else if (r < put_pct + 7)
      purge();
    else
      tick();
  endtask

  // Fill the whole font so that no tick ever shows an unwritten row.
  task automatic test_font_load();
    int a;
    for (a = 0; a < FONT_ROWS; a++)
      send_item(OP_FONT, CHAR_W'($urandom), FADDR_W'(a), ROW_W'($urandom));
    wait_results_drained();
  endtask

  // Default delay holds the scroll, then a lower delay steps it at the next tick.
  task automatic test_delay_lowered();
    put_char(8'h48);
    put_char(8'h49);
    repeat (12) tick();
    wait_results_drained();
    write_scroll_delay(16'd3);
    repeat (6) tick();
    wait_results_drained();
    write_scroll_delay('1);
    repeat (4) tick();
    wait_results_drained();
    // Unmapped register: the delay must stay at its maximum.
    apb_write(SPARE_REG_ADDR, '0);
    repeat (3) tick();
    wait_results_drained();
  endtask

  // Gap clearing busy, dark codes, font edges and purge.
  task automatic test_special_cases();
    write_scroll_delay('0);
    purge();
    put_char(8'h00);
    tick();
    put_char(FIRST_GLYPH_CODE);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(8'h1F);
    put_char(8'hFF);
    put_char(8'h41);
    repeat (8) tick();
    send_item(OP_FONT, 8'h00, FADDR_W'(FONT_ROWS), 8'hFF);
    send_item(OP_FONT, 8'hFF, '1, 8'hFF);
    repeat (4) tick();
    purge();
    tick();
    wait_results_drained();
  endtask

  // Overfill the ring, drain part of it and wrap the write pointer.
  task automatic test_buffer_full();
    write_scroll_delay(16'd1);
    purge();
    repeat (RING_DEPTH + 2) put_char(pick_char());
    repeat (24) tick();
    repeat (12) put_char(pick_char());
    repeat (8) tick();
    wait_results_drained();
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_receiver_hold();
    idle_on = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_random_item(30);
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // Segments of random traffic, each under its own delay and idling choice.
  task automatic test_random_traffic();
    int sent, seg_end, put_pct, burst;
    logic [DELAY_W-1:0] dly;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_results_drained();
      case ($urandom_range(0, 9))
        0:       dly = '0;
        1:       dly = '1;
        2:       dly = DELAY_W'($urandom);
        3, 4:    dly = DELAY_W'($urandom_range(4, 40));
        default: dly = DELAY_W'($urandom_range(0, 3));
      endcase
      write_scroll_delay(dly);
      idle_on = (RANDOM_ITEMS - sent > CALM_TAIL) && ($urandom_range(0, 3) != 0);
      put_pct = $urandom_range(5, 45);
      seg_end = sent + $urandom_range(40, 120);
      while (sent < seg_end && sent < RANDOM_ITEMS) begin
        // The closing stretch of the run goes without idling.
        if (RANDOM_ITEMS - sent <= CALM_TAIL) idle_on = 1'b0;
        if ($urandom_range(0, 60) == 0) begin
          burst = $urandom_range(10, 70);
          repeat (burst) put_char(pick_char());
          sent += burst;
        end else begin
          send_random_item(put_pct);
          sent++;
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_font_load();
    test_delay_lowered();
    test_special_cases();
    test_buffer_full();
    test_receiver_hold();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d puts (%0d refused at a full ring), %0d ticks,", op_seen[OP_PUT],
             refused_puts, op_seen[OP_TICK],
             " %0d font writes, %0d purges, %0d delay settings.",
             op_seen[OP_FONT], op_seen[OP_PURGE], delay_settings);
    $display("Compared %0d result items, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
